// File: rtl/core/stretch_blit_setup_top_macros.svh
// Assertion shorthands for the stretch blit setup checker.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef STRETCH_BLIT_SETUP_TOP_MACROS_SVH
`define STRETCH_BLIT_SETUP_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Stretch blit setup package
// Shared widths, codes, beat formats and sequencer states.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int COORD_W = 16;
    localparam int RES_W   = 15;
    localparam int NUM_W   = 19;
    localparam int DEN_W   = 18;
    localparam int FRAC_W  = 40;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = 40;
    localparam int DIV_W   = 38;
    localparam int DVS_W   = 20;

    typedef enum logic [1:0] {
        CMD_DEST = 2'd0,
        CMD_SRC  = 2'd1,
        CMD_CLIP = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CL_DEST = 2'd0,
        CL_SRC  = 2'd1,
        CL_CLIP = 2'd2
    } item_class_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_X      = 2'd1,
        KIND_Y      = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_COPY   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_SRC_X = 2'd0,
        CFG_SRC_Y = 2'd1,
        CFG_DST_X = 2'd2,
        CFG_DST_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [RES_W-1:0] src_x_res;
        logic [RES_W-1:0] src_y_res;
        logic [RES_W-1:0] dst_x_res;
        logic [RES_W-1:0] dst_y_res;
    } cfg_t;

    typedef struct packed {
        item_class_t               cls;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic [14:0]        dst_start;
        logic [14:0]        span_length;
        logic signed [16:0] src_start;
        logic signed [17:0] err_start;
        logic signed [16:0] src_step;
        logic signed [1:0]  src_dir;
        logic [17:0]        err_step;
        logic [17:0]        denominator;
        logic               last;
    } result_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_SORT,
        SQ_FIT_CHK,
        SQ_FIT_MA,
        SQ_FIT_DA,
        SQ_FIT_WA,
        SQ_FIT_MB,
        SQ_FIT_DB,
        SQ_FIT_WB,
        SQ_FIT_NARROW,
        SQ_SCREEN,
        SQ_FR_M1,
        SQ_FR_M2,
        SQ_FR_ADD,
        SQ_STATUS,
        SQ_CLIP,
        SQ_EM_MUL,
        SQ_EM_ADD,
        SQ_EM_D1,
        SQ_EM_W1,
        SQ_EM_D2,
        SQ_EM_W2,
        SQ_EM_OUT
    } seq_state_t;

endpackage

// File: rtl/core/stbs_fifo.sv
// ----------------------------------------------------------------------------
// Stretch blit setup queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module stbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/core/stbs_front.sv
// ----------------------------------------------------------------------------
// Stretch blit setup front end
// Accepts input beats, decodes the command and queues work for the back end.
// ----------------------------------------------------------------------------
module stbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic signed [15:0]  x1,
    input  logic signed [15:0]  y1,
    input  logic signed [15:0]  x2,
    input  logic signed [15:0]  y2,
    output logic                item_valid,
    output stbs_pkg::item_t     item,
    input  logic                item_pop
);

    stbs_pkg::item_t     item_in;
    logic                keep;
    logic                q_empty;
    logic [stbs_pkg::ITEM_W-1:0] q_dout;

    // Unknown commands are taken from the port and dropped here.
    always_comb
    begin
        item_in.x1  = x1;
        item_in.y1  = y1;
        item_in.x2  = x2;
        item_in.y2  = y2;
        item_in.cls = stbs_pkg::CL_DEST;
        keep        = 1'b1;
        case (stbs_pkg::cmd_t'(command))
            stbs_pkg::CMD_DEST: item_in.cls = stbs_pkg::CL_DEST;
            stbs_pkg::CMD_SRC:  item_in.cls = stbs_pkg::CL_SRC;
            stbs_pkg::CMD_CLIP: item_in.cls = stbs_pkg::CL_CLIP;
            default:            keep        = 1'b0;
        endcase
    end

    stbs_fifo #(
        .WIDTH (stbs_pkg::ITEM_W),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .din   (item_in),
        .full  (full),
        .pop   (item_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;
    assign item       = stbs_pkg::item_t'(q_dout);

endmodule

// File: rtl/core/stbs_div.sv
// ----------------------------------------------------------------------------
// Stretch blit setup divider
// Signed truncating division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stbs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [stbs_pkg::DIV_W-1:0]   dividend,
    input  logic signed [stbs_pkg::DVS_W-1:0]   divisor,
    output logic                                done,
    output logic signed [stbs_pkg::DIV_W-1:0]   quotient,
    output logic signed [stbs_pkg::DVS_W-1:0]   remainder
);

    localparam int DW    = stbs_pkg::DIV_W;
    localparam int SW    = stbs_pkg::DVS_W;
    localparam int CNT_W = $clog2(DW);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    dvs_reg;
    logic             negq_reg;
    logic             negr_reg;
    logic [DW-1:0]    dnd_mag;
    logic [SW-1:0]    dvs_mag;
    logic [SW:0]      trial;
    logic [SW:0]      diff;
    logic             fits;

    assign dnd_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign dvs_mag = divisor[SW-1] ? SW'(-divisor) : SW'(divisor);

    // Restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign done      = done_reg;
    assign quotient  = negq_reg ? DW'(-quo_reg) : quo_reg;
    assign remainder = negr_reg ? SW'(-rem_reg) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dnd_mag;
            rem_reg  <= '0;
            dvs_reg  <= dvs_mag;
            negq_reg <= dividend[DW-1] ^ divisor[SW-1];
            negr_reg <= dividend[DW-1];
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[SW-1:0] : trial[SW-1:0];
        end
    end

endmodule

// File: rtl/core/stbs_back.sv
// ----------------------------------------------------------------------------
// Stretch blit setup back end
// Sequencer that evaluates requests and emits per-axis stepping terms.
// ----------------------------------------------------------------------------
module stbs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stbs_pkg::cfg_t     cfg,
    input  logic               item_valid,
    input  stbs_pkg::item_t    item,
    output logic               item_pop,
    input  logic               res_full,
    output logic               res_push,
    output stbs_pkg::result_t  res_data
);

    localparam int DW = stbs_pkg::DIV_W;
    localparam int SW = stbs_pkg::DVS_W;
    localparam int PW = stbs_pkg::PROD_W;
    localparam int FW = stbs_pkg::FRAC_W;

    stbs_pkg::seq_state_t state_reg;
    stbs_pkg::seq_state_t state_next;
    logic                 ax_reg;
    logic                 active_reg;
    logic signed [15:0]   dc_reg [4];
    stbs_pkg::item_t      item_reg;
    stbs_pkg::status_t    stat_reg;

    // Request state kept for the clip rectangles that follow.
    logic signed [15:0]   clo_reg [2];
    logic signed [15:0]   chi_reg [2];
    logic signed [18:0]   num_reg [2];
    logic [17:0]          den_reg [2];
    logic signed [FW-1:0] frac_reg [2];

    // Evaluation scratch, one entry per axis.
    logic signed [15:0]   wd1_reg [2];
    logic signed [15:0]   ws1_reg [2];
    logic signed [15:0]   ws2_reg [2];
    logic signed [15:0]   wlo_reg [2];
    logic signed [15:0]   whi_reg [2];
    logic signed [18:0]   wnum_reg [2];
    logic [17:0]          wden_reg [2];
    logic signed [39:0]   bnd_a_reg;
    logic signed [39:0]   bnd_b_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;

    // Emission scratch.
    logic signed [15:0]   r1_reg [2];
    logic signed [15:0]   r2_reg [2];
    logic signed [PW-1:0] efrac_reg;
    logic signed [16:0]   whole_reg;
    logic signed [17:0]   err_reg;
    logic signed [16:0]   step_reg;
    logic [17:0]          estep_reg;

    logic signed [19:0]   mul_a;
    logic signed [19:0]   mul_b;
    logic                 div_start;
    logic signed [DW-1:0] div_dividend;
    logic signed [SW-1:0] div_divisor;
    logic                 div_done;
    logic signed [DW-1:0] div_quo;
    logic signed [SW-1:0] div_rem;

    // Sort stage.
    logic signed [15:0]   s_dx1, s_dx2, s_sx1, s_sx2;
    logic signed [15:0]   s_dy1, s_dy2, s_sy1, s_sy2;
    logic signed [16:0]   s_dxd, s_dyd, s_sxd, s_syd;
    logic signed [18:0]   s_nx, s_ny, s_ex, s_ey;
    logic signed [16:0]   dres_x, dres_y;
    logic                 s_reject;
    logic                 s_copy;

    // Source fit for the current axis.
    logic signed [15:0]   f_d1, f_s1, f_s2, f_lo, f_hi;
    logic signed [18:0]   f_num;
    logic [17:0]          f_den;
    logic signed [16:0]   f_sres;
    logic signed [17:0]   f_res_s1;
    logic signed [16:0]   f_lo_d1;
    logic                 f_inside;
    logic signed [39:0]   n_lo, n_hi, lo40, hi40;
    logic                 n_reject;
    logic signed [PW-1:0] db_dividend;

    // Screen clamp.
    logic signed [15:0]   sc_lo [2];
    logic signed [15:0]   sc_hi [2];
    logic signed [16:0]   sc_res [2];
    logic                 sc_reject;

    // Clip and emission.
    logic signed [15:0]   c_a, c_b, c_c, c_d;
    logic                 c_hit;
    logic signed [16:0]   e_off;
    logic signed [PW-1:0] e_frac;
    logic signed [19:0]   e_err;
    logic [SW-1:0]        e_estep;
    logic signed [1:0]    e_dir;

    stbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sort corners per axis; the source pair follows the destination pair.
    always_comb
    begin
        if (dc_reg[0] > dc_reg[2])
        begin
            s_dx1 = dc_reg[2];
            s_dx2 = dc_reg[0];
            s_sx1 = item_reg.x2;
            s_sx2 = item_reg.x1;
        end
        else
        begin
            s_dx1 = dc_reg[0];
            s_dx2 = dc_reg[2];
            s_sx1 = item_reg.x1;
            s_sx2 = item_reg.x2;
        end
        if (dc_reg[1] > dc_reg[3])
        begin
            s_dy1 = dc_reg[3];
            s_dy2 = dc_reg[1];
            s_sy1 = item_reg.y2;
            s_sy2 = item_reg.y1;
        end
        else
        begin
            s_dy1 = dc_reg[1];
            s_dy2 = dc_reg[3];
            s_sy1 = item_reg.y1;
            s_sy2 = item_reg.y2;
        end
        s_dxd    = 17'(s_dx2) - 17'(s_dx1);
        s_dyd    = 17'(s_dy2) - 17'(s_dy1);
        s_sxd    = 17'(s_sx2) - 17'(s_sx1);
        s_syd    = 17'(s_sy2) - 17'(s_sy1);
        s_nx     = (19'(s_sxd) + 19'sd1) <<< 1;
        s_ny     = (19'(s_syd) + 19'sd1) <<< 1;
        s_ex     = (19'(s_dxd) + 19'sd1) <<< 1;
        s_ey     = (19'(s_dyd) + 19'sd1) <<< 1;
        dres_x   = signed'({2'b00, cfg.dst_x_res});
        dres_y   = signed'({2'b00, cfg.dst_y_res});
        s_reject = (s_dx2 < 0) || (s_dy2 < 0) || (17'(s_dx1) > dres_x)
                   || (17'(s_dy1) > dres_y) || (s_dx1 == s_dx2) || (s_dy1 == s_dy2);
        s_copy   = (s_dxd == s_sxd) && (s_dyd == s_syd);
    end

    always_comb
    begin
        f_d1     = wd1_reg[ax_reg];
        f_s1     = ws1_reg[ax_reg];
        f_s2     = ws2_reg[ax_reg];
        f_lo     = wlo_reg[ax_reg];
        f_hi     = whi_reg[ax_reg];
        f_num    = wnum_reg[ax_reg];
        f_den    = wden_reg[ax_reg];
        f_sres   = ax_reg ? signed'({2'b00, cfg.src_y_res}) : signed'({2'b00, cfg.src_x_res});
        f_res_s1 = 18'(f_sres) - 18'(f_s1);
        f_lo_d1  = 17'(f_lo) - 17'(f_d1);
        f_inside = (f_s1 >= 0) && (17'(f_s1) <= f_sres) && (f_s2 >= 0) && (17'(f_s2) <= f_sres);
        db_dividend = prod_reg + signed'(PW'(f_den)) - PW'(1);
        if (bnd_a_reg > bnd_b_reg)
        begin
            n_lo = bnd_b_reg;
            n_hi = bnd_a_reg;
        end
        else
        begin
            n_lo = bnd_a_reg;
            n_hi = bnd_b_reg;
        end
        lo40     = 40'(f_lo);
        hi40     = 40'(f_hi);
        n_reject = (hi40 < n_lo) || (lo40 > n_hi);
    end

    always_comb
    begin
        sc_res[0] = dres_x;
        sc_res[1] = dres_y;
        sc_reject = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            sc_lo[i] = (wlo_reg[i] < 0) ? 16'sd0 : wlo_reg[i];
            sc_hi[i] = (17'(whi_reg[i]) > sc_res[i]) ? sc_res[i][15:0] : whi_reg[i];
            if (sc_lo[i] >= sc_hi[i])
            begin
                sc_reject = 1'b1;
            end
        end
    end

    always_comb
    begin
        c_a     = (item_reg.x1 < clo_reg[0]) ? clo_reg[0] : item_reg.x1;
        c_b     = (item_reg.y1 < clo_reg[1]) ? clo_reg[1] : item_reg.y1;
        c_c     = (item_reg.x2 > chi_reg[0]) ? chi_reg[0] : item_reg.x2;
        c_d     = (item_reg.y2 > chi_reg[1]) ? chi_reg[1] : item_reg.y2;
        c_hit   = (c_a < c_c) && (c_b < c_d);
        e_off   = 17'(r1_reg[ax_reg]) - 17'(clo_reg[ax_reg]);
        e_frac  = PW'(frac_reg[ax_reg]) + prod_reg + PW'(num_reg[ax_reg] >>> 1);
        e_err   = div_rem - signed'(SW'(den_reg[ax_reg]));
        e_estep = div_rem[SW-1] ? SW'(-div_rem) : div_rem;
        if (num_reg[ax_reg] > 0)
        begin
            e_dir = 2'sd1;
        end
        else if (num_reg[ax_reg] < 0)
        begin
            e_dir = -2'sd1;
        end
        else
        begin
            e_dir = 2'sd0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stbs_pkg::SQ_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.cls)
                        stbs_pkg::CL_SRC:  state_next = stbs_pkg::SQ_SORT;
                        stbs_pkg::CL_CLIP:
                        begin
                            if (active_reg)
                            begin
                                state_next = stbs_pkg::SQ_CLIP;
                            end
                        end
                        default:           state_next = stbs_pkg::SQ_IDLE;
                    endcase
                end
            end
            stbs_pkg::SQ_SORT:
            begin
                state_next = (s_reject || s_copy) ? stbs_pkg::SQ_STATUS : stbs_pkg::SQ_FIT_CHK;
            end
            stbs_pkg::SQ_FIT_CHK:
            begin
                if (f_inside)
                begin
                    state_next = ax_reg ? stbs_pkg::SQ_SCREEN : stbs_pkg::SQ_FIT_CHK;
                end
                else if (f_num == 0)
                begin
                    state_next = stbs_pkg::SQ_STATUS;
                end
                else
                begin
                    state_next = stbs_pkg::SQ_FIT_MA;
                end
            end
            stbs_pkg::SQ_FIT_MA: state_next = stbs_pkg::SQ_FIT_DA;
            stbs_pkg::SQ_FIT_DA: state_next = stbs_pkg::SQ_FIT_WA;
            stbs_pkg::SQ_FIT_WA:
            begin
                if (div_done)
                begin
                    state_next = stbs_pkg::SQ_FIT_MB;
                end
            end
            stbs_pkg::SQ_FIT_MB: state_next = stbs_pkg::SQ_FIT_DB;
            stbs_pkg::SQ_FIT_DB: state_next = stbs_pkg::SQ_FIT_WB;
            stbs_pkg::SQ_FIT_WB:
            begin
                if (div_done)
                begin
                    state_next = stbs_pkg::SQ_FIT_NARROW;
                end
            end
            stbs_pkg::SQ_FIT_NARROW:
            begin
                if (n_reject)
                begin
                    state_next = stbs_pkg::SQ_STATUS;
                end
                else
                begin
                    state_next = ax_reg ? stbs_pkg::SQ_SCREEN : stbs_pkg::SQ_FIT_CHK;
                end
            end
            stbs_pkg::SQ_SCREEN:
            begin
                state_next = sc_reject ? stbs_pkg::SQ_STATUS : stbs_pkg::SQ_FR_M1;
            end
            stbs_pkg::SQ_FR_M1: state_next = stbs_pkg::SQ_FR_M2;
            stbs_pkg::SQ_FR_M2: state_next = stbs_pkg::SQ_FR_ADD;
            stbs_pkg::SQ_FR_ADD:
            begin
                state_next = ax_reg ? stbs_pkg::SQ_STATUS : stbs_pkg::SQ_FR_M1;
            end
            stbs_pkg::SQ_STATUS:
            begin
                if (!res_full)
                begin
                    state_next = stbs_pkg::SQ_IDLE;
                end
            end
            stbs_pkg::SQ_CLIP:
            begin
                state_next = c_hit ? stbs_pkg::SQ_EM_MUL : stbs_pkg::SQ_IDLE;
            end
            stbs_pkg::SQ_EM_MUL: state_next = stbs_pkg::SQ_EM_ADD;
            stbs_pkg::SQ_EM_ADD: state_next = stbs_pkg::SQ_EM_D1;
            stbs_pkg::SQ_EM_D1:  state_next = stbs_pkg::SQ_EM_W1;
            stbs_pkg::SQ_EM_W1:
            begin
                if (div_done)
                begin
                    state_next = stbs_pkg::SQ_EM_D2;
                end
            end
            stbs_pkg::SQ_EM_D2:  state_next = stbs_pkg::SQ_EM_W2;
            stbs_pkg::SQ_EM_W2:
            begin
                if (div_done)
                begin
                    state_next = stbs_pkg::SQ_EM_OUT;
                end
            end
            stbs_pkg::SQ_EM_OUT:
            begin
                if (!res_full)
                begin
                    state_next = ax_reg ? stbs_pkg::SQ_IDLE : stbs_pkg::SQ_EM_MUL;
                end
            end
            default: state_next = stbs_pkg::SQ_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier and divider operands, pops, pushes.
    always_comb
    begin
        item_pop     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        res_push     = 1'b0;
        res_data     = '0;
        case (state_reg)
            stbs_pkg::SQ_IDLE:
            begin
                item_pop = item_valid;
            end
            stbs_pkg::SQ_FIT_MA, stbs_pkg::SQ_FR_M1:
            begin
                mul_a = 20'(f_s1);
                mul_b = signed'(20'(f_den));
            end
            stbs_pkg::SQ_FIT_MB:
            begin
                mul_a = 20'(f_res_s1);
                mul_b = signed'(20'(f_den));
            end
            stbs_pkg::SQ_FR_M2:
            begin
                mul_a = 20'(f_lo_d1);
                mul_b = 20'(f_num);
            end
            stbs_pkg::SQ_EM_MUL:
            begin
                mul_a = 20'(e_off);
                mul_b = 20'(num_reg[ax_reg]);
            end
            stbs_pkg::SQ_FIT_DA:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg[DW-1:0];
                div_divisor  = 20'(f_num);
            end
            stbs_pkg::SQ_FIT_DB:
            begin
                div_start    = 1'b1;
                div_dividend = db_dividend[DW-1:0];
                div_divisor  = 20'(f_num);
            end
            stbs_pkg::SQ_EM_D1:
            begin
                div_start    = 1'b1;
                div_dividend = efrac_reg[DW-1:0];
                div_divisor  = signed'(SW'(den_reg[ax_reg]));
            end
            stbs_pkg::SQ_EM_D2:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(num_reg[ax_reg]);
                div_divisor  = signed'(SW'(den_reg[ax_reg]));
            end
            stbs_pkg::SQ_STATUS:
            begin
                res_push        = !res_full;
                res_data.kind   = stbs_pkg::KIND_STATUS;
                res_data.status = stat_reg;
                res_data.last   = 1'b1;
            end
            stbs_pkg::SQ_EM_OUT:
            begin
                res_push             = !res_full;
                res_data.kind        = ax_reg ? stbs_pkg::KIND_Y : stbs_pkg::KIND_X;
                res_data.status      = stbs_pkg::STAT_ACCEPT;
                res_data.dst_start   = r1_reg[ax_reg][14:0];
                res_data.span_length = 15'(r2_reg[ax_reg] - r1_reg[ax_reg]);
                res_data.src_start   = whole_reg;
                res_data.err_start   = err_reg;
                res_data.src_step    = step_reg;
                res_data.src_dir     = e_dir;
                res_data.err_step    = estep_reg;
                res_data.denominator = den_reg[ax_reg];
                res_data.last        = ax_reg;
            end
            default:
            begin
                item_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stbs_pkg::SQ_IDLE;
            ax_reg     <= 1'b0;
            active_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                dc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                stbs_pkg::SQ_IDLE:
                begin
                    ax_reg <= 1'b0;
                    if (item_valid && (item.cls == stbs_pkg::CL_DEST))
                    begin
                        dc_reg[0]  <= item.x1;
                        dc_reg[1]  <= item.y1;
                        dc_reg[2]  <= item.x2;
                        dc_reg[3]  <= item.y2;
                        active_reg <= 1'b0;
                    end
                end
                stbs_pkg::SQ_FIT_CHK:
                begin
                    if (f_inside)
                    begin
                        ax_reg <= 1'b1;
                    end
                end
                stbs_pkg::SQ_FIT_NARROW:
                begin
                    ax_reg <= 1'b1;
                end
                stbs_pkg::SQ_SCREEN:
                begin
                    ax_reg <= 1'b0;
                end
                stbs_pkg::SQ_FR_ADD:
                begin
                    ax_reg <= 1'b1;
                end
                stbs_pkg::SQ_STATUS:
                begin
                    if (!res_full)
                    begin
                        active_reg <= (stat_reg == stbs_pkg::STAT_ACCEPT);
                    end
                end
                stbs_pkg::SQ_CLIP:
                begin
                    ax_reg <= 1'b0;
                end
                stbs_pkg::SQ_EM_OUT:
                begin
                    if (!res_full)
                    begin
                        ax_reg <= 1'b1;
                    end
                end
                default:
                begin
                    ax_reg <= ax_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            stbs_pkg::SQ_IDLE:
            begin
                if (item_valid)
                begin
                    item_reg <= item;
                end
            end
            stbs_pkg::SQ_SORT:
            begin
                wd1_reg[0]  <= s_dx1;
                wd1_reg[1]  <= s_dy1;
                ws1_reg[0]  <= s_sx1;
                ws1_reg[1]  <= s_sy1;
                ws2_reg[0]  <= s_sx2;
                ws2_reg[1]  <= s_sy2;
                wlo_reg[0]  <= s_dx1;
                wlo_reg[1]  <= s_dy1;
                whi_reg[0]  <= s_dx2;
                whi_reg[1]  <= s_dy2;
                wnum_reg[0] <= s_nx;
                wnum_reg[1] <= s_ny;
                wden_reg[0] <= s_ex[17:0];
                wden_reg[1] <= s_ey[17:0];
                if (s_reject)
                begin
                    stat_reg <= stbs_pkg::STAT_EMPTY;
                end
                else if (s_copy)
                begin
                    stat_reg <= stbs_pkg::STAT_COPY;
                end
                else
                begin
                    stat_reg <= stbs_pkg::STAT_ACCEPT;
                end
            end
            stbs_pkg::SQ_FIT_CHK:
            begin
                if (!f_inside && (f_num == 0))
                begin
                    stat_reg <= stbs_pkg::STAT_EMPTY;
                end
            end
            stbs_pkg::SQ_FIT_WA:
            begin
                bnd_a_reg <= 40'(f_d1) - 40'(div_quo);
            end
            stbs_pkg::SQ_FIT_WB:
            begin
                bnd_b_reg <= 40'(f_d1) + 40'(div_quo);
            end
            stbs_pkg::SQ_FIT_NARROW:
            begin
                if (n_reject)
                begin
                    stat_reg <= stbs_pkg::STAT_EMPTY;
                end
                if (lo40 < n_lo)
                begin
                    wlo_reg[ax_reg] <= n_lo[15:0];
                end
                if (hi40 > n_hi)
                begin
                    whi_reg[ax_reg] <= n_hi[15:0];
                end
            end
            stbs_pkg::SQ_SCREEN:
            begin
                if (sc_reject)
                begin
                    stat_reg <= stbs_pkg::STAT_EMPTY;
                end
                for (int i = 0; i < 2; i++)
                begin
                    wlo_reg[i] <= sc_lo[i];
                    whi_reg[i] <= sc_hi[i];
                end
            end
            stbs_pkg::SQ_FR_M2:
            begin
                acc_reg <= prod_reg;
            end
            stbs_pkg::SQ_FR_ADD:
            begin
                clo_reg[ax_reg]  <= f_lo;
                chi_reg[ax_reg]  <= f_hi;
                num_reg[ax_reg]  <= f_num;
                den_reg[ax_reg]  <= f_den;
                frac_reg[ax_reg] <= FW'(acc_reg + prod_reg);
            end
            stbs_pkg::SQ_CLIP:
            begin
                r1_reg[0] <= c_a;
                r2_reg[0] <= c_c;
                r1_reg[1] <= c_b;
                r2_reg[1] <= c_d;
            end
            stbs_pkg::SQ_EM_ADD:
            begin
                efrac_reg <= e_frac;
            end
            stbs_pkg::SQ_EM_W1:
            begin
                if (div_done)
                begin
                    whole_reg <= div_quo[16:0];
                    err_reg   <= e_err[17:0];
                end
            end
            stbs_pkg::SQ_EM_W2:
            begin
                if (div_done)
                begin
                    step_reg  <= div_quo[16:0];
                    estep_reg <= e_estep[17:0];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// File: rtl/core/stretch_blit_setup_top.sv
// ----------------------------------------------------------------------------
// Stretch blit setup
// Front end of a 2D stretch blitter: corner sorting, rejection, clipping and
// per-axis stepping terms for each clip rectangle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         push / full        command, x1, y1, x2, y2
//  result    out        empty / pop        kind .. last (11 fields)
//  config    in         cfg_we             cfg_index, cfg_data
//
//  A destination item leaves the input queue once the back end is idle; a
//  rejected or unscaled source item has its status beat pushed once the result
//  queue has room. A source item fitted to the source extent on an axis, and a
//  clip rectangle on each axis, use two divisions on the shared 38-step divider.
//  Two input beats queue up while the back end works, and two result beats wait
//  for pop. Reset is asynchronous.
// ----------------------------------------------------------------------------
module stretch_blit_setup_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic signed [15:0] x1,
    input  logic signed [15:0] y1,
    input  logic signed [15:0] x2,
    input  logic signed [15:0] y2,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [14:0]        dst_start,
    output logic [14:0]        span_length,
    output logic signed [16:0] src_start,
    output logic signed [17:0] err_start,
    output logic signed [16:0] src_step,
    output logic signed [1:0]  src_dir,
    output logic [17:0]        err_step,
    output logic [17:0]        denominator,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    stbs_pkg::cfg_t    cfg_reg;
    logic              item_valid;
    stbs_pkg::item_t   item;
    logic              item_pop;
    logic              res_full;
    logic              res_push;
    stbs_pkg::result_t res_data;
    logic [stbs_pkg::RESULT_W-1:0] res_dout;
    stbs_pkg::result_t res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_x_res <= 15'd640;
            cfg_reg.src_y_res <= 15'd480;
            cfg_reg.dst_x_res <= 15'd640;
            cfg_reg.dst_y_res <= 15'd480;
        end
        else if (cfg_we)
        begin
            case (stbs_pkg::cfg_idx_t'(cfg_index))
                stbs_pkg::CFG_SRC_X: cfg_reg.src_x_res <= cfg_data;
                stbs_pkg::CFG_SRC_Y: cfg_reg.src_y_res <= cfg_data;
                stbs_pkg::CFG_DST_X: cfg_reg.dst_x_res <= cfg_data;
                stbs_pkg::CFG_DST_Y: cfg_reg.dst_y_res <= cfg_data;
                default:             cfg_reg           <= cfg_reg;
            endcase
        end
    end

    stbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .x1         (x1),
        .y1         (y1),
        .x2         (x2),
        .y2         (y2),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    stbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    stbs_fifo #(
        .WIDTH (stbs_pkg::RESULT_W),
        .DEPTH (2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_data),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign res_head    = stbs_pkg::result_t'(res_dout);
    assign kind        = res_head.kind;
    assign status      = res_head.status;
    assign dst_start   = res_head.dst_start;
    assign span_length = res_head.span_length;
    assign src_start   = res_head.src_start;
    assign err_start   = res_head.err_start;
    assign src_step    = res_head.src_step;
    assign src_dir     = res_head.src_dir;
    assign err_step    = res_head.err_step;
    assign denominator = res_head.denominator;
    assign last        = res_head.last;

endmodule

// File: rtl/core/stbs_checker.sv
// ----------------------------------------------------------------------------
// Stretch blit setup checker
// Port-level checks on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "stretch_blit_setup_top_macros.svh"

module stbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         kind,
    input logic [1:0]         status,
    input logic [14:0]        dst_start,
    input logic [17:0]        err_step,
    input logic [17:0]        denominator,
    input logic               last
);

    // A status beat is always the only beat of its item.
    `STBS_ASSERT_NOW(a_status_last, !empty && kind == stbs_pkg::KIND_STATUS, last, "status beat without last")

    // Only the y beat closes a clip rectangle.
    `STBS_ASSERT_NOW(a_axis_last, !empty && kind != stbs_pkg::KIND_STATUS, last == (kind == stbs_pkg::KIND_Y), "axis beat with wrong last")

    // Axis beats carry an accepted status and a live denominator.
    `STBS_ASSERT_NOW(a_axis_den, !empty && kind != stbs_pkg::KIND_STATUS, status == stbs_pkg::STAT_ACCEPT && denominator != 18'd0, "axis beat with bad status or zero denominator")

    // The error increment is a remainder of the denominator.
    `STBS_ASSERT_NOW(a_err_step, !empty && kind != stbs_pkg::KIND_STATUS, err_step < denominator, "error step not below denominator")

    `STBS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(dst_start), "waiting beat changed")

endmodule

bind stretch_blit_setup_top stbs_checker u_stbs_checker (.*);
